// ----- hdl/smta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smta_pkg
// Shared types, codes and default sizes of the sparse term accumulator.
// ----------------------------------------------------------------------------
package smta_pkg;

    localparam int MAX_TERMS_DEF = 64;
    localparam int EXP_BITS_DEF  = 8;
    localparam int COEF_W        = 32;

    typedef enum logic [0:0] {
        OP_ADD  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_MERGED   = 3'd0,
        ST_APPENDED = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_FULL     = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_READ_OOR = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic shift;
        logic write;
    } cell_ctrl_t;

endpackage

// ----- hdl/smta_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smta_cell
// One table slot: holds a coefficient and packed exponents, flags a lookup
// hit and takes its upper neighbor's term when the table closes a gap.
// ----------------------------------------------------------------------------
module smta_cell
    import smta_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int SLOT_W   = 6,
    parameter int CNT_W    = 7,
    parameter int EXP_BITS = EXP_BITS_DEF
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [SLOT_W-1:0]     upd_slot,
    input  logic [COEF_W-1:0]     wr_coef,
    input  logic [3*EXP_BITS-1:0] wr_exps,
    input  logic [COEF_W-1:0]     nxt_coef,
    input  logic [3*EXP_BITS-1:0] nxt_exps,
    input  op_t                   look_op,
    input  logic [3*EXP_BITS-1:0] key_exps,
    input  logic [5:0]            read_index,
    input  logic [CNT_W-1:0]      count,
    output logic [COEF_W-1:0]     coef,
    output logic [3*EXP_BITS-1:0] exps,
    output logic                  sel
);

    localparam int RD_W = (CNT_W > 6) ? CNT_W : 6;
    localparam logic [SLOT_W-1:0] IDX_S = SLOT_W'(IDX);
    localparam logic [CNT_W-1:0]  IDX_C = CNT_W'(IDX);
    localparam logic [RD_W-1:0]   IDX_R = RD_W'(IDX);

    logic [COEF_W-1:0]     coef_reg;
    logic [3*EXP_BITS-1:0] exps_reg;
    logic                  active;
    logic                  do_shift;
    logic                  do_write;

    assign active   = (IDX_C < count);
    assign do_shift = ctrl.shift && (IDX_S >= upd_slot);
    assign do_write = ctrl.write && (IDX_S == upd_slot);

    always_comb
    begin
        case (look_op)
            OP_READ: sel = active && (RD_W'(read_index) == IDX_R);
            default: sel = active && (exps_reg == key_exps);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_shift)
        begin
            coef_reg <= nxt_coef;
            exps_reg <= nxt_exps;
        end
        else if (do_write)
        begin
            coef_reg <= wr_coef;
            exps_reg <= wr_exps;
        end
    end

    assign coef = coef_reg;
    assign exps = exps_reg;

endmodule

// ----- hdl/sparse_monomial_term_accumulator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_monomial_term_accumulator
// Table of three-variable polynomial terms kept in a row of slot cells.
// ----------------------------------------------------------------------------
// In the cycle an item is offered, every cell compares its term against the
// item at once and the hit is captured when the beat is accepted; then the
// single update stage adds the coefficients, writes the hit cell, appends at
// the end or shifts the upper cells down one slot, and loads the result
// register. A new item is accepted while a result waits; only a second
// result arriving before the first is taken stalls.
// ----------------------------------------------------------------------------
module sparse_monomial_term_accumulator
    import smta_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int EXP_BITS  = EXP_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [0:0]  op,
    input  logic signed [31:0] coef_in,
    input  logic [7:0]  exp_x_in,
    input  logic [7:0]  exp_y_in,
    input  logic [7:0]  exp_z_in,
    input  logic [5:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [5:0]  slot,
    output logic signed [31:0] coef_out,
    output logic [7:0]  exp_x_out,
    output logic [7:0]  exp_y_out,
    output logic [7:0]  exp_z_out,
    output logic [6:0]  term_count
);

    localparam int SLOT_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int XW     = 3 * EXP_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;

    op_t                op_reg;
    logic [COEF_W-1:0]  coef_reg;
    logic [XW-1:0]      key_reg;
    logic [5:0]         idx_reg;
    logic               hit_reg;
    logic [COEF_W-1:0]  hcoef_reg;
    logic [XW-1:0]      hexps_reg;
    logic [SLOT_W-1:0]  hslot_reg;

    logic [2:0]         status_reg, status_next;
    logic [5:0]         slot_reg, slot_next;
    logic [COEF_W-1:0]  coef_out_reg, coef_out_next;
    logic [XW-1:0]      exps_out_reg, exps_out_next;
    logic [6:0]         tc_reg, tc_next;

    logic [XW-1:0]      key_in;
    logic [COEF_W-1:0]  cell_coef [MAX_TERMS];
    logic [XW-1:0]      cell_exps [MAX_TERMS];
    logic [MAX_TERMS-1:0] cell_sel;
    logic               look_hit;
    logic [COEF_W-1:0]  look_coef;
    logic [XW-1:0]      look_exps;
    logic [SLOT_W-1:0]  look_slot;

    logic               accept;
    logic               fire;
    cell_ctrl_t         ctrl;
    logic [SLOT_W-1:0]  upd_slot;
    logic [COEF_W-1:0]  wr_coef;
    logic [COEF_W:0]    sum_wide;
    logic [COEF_W-1:0]  sum_sat;

    assign key_in = {EXP_BITS'(exp_z_in), EXP_BITS'(exp_y_in), EXP_BITS'(exp_x_in)};

    // slot cells
    for (genvar g = 0; g < MAX_TERMS; g++)
    begin : g_cell
        logic [COEF_W-1:0] up_coef;
        logic [XW-1:0]     up_exps;
        if (g == MAX_TERMS - 1)
        begin : g_top
            assign up_coef = cell_coef[g];
            assign up_exps = cell_exps[g];
        end
        else
        begin : g_mid
            assign up_coef = cell_coef[g+1];
            assign up_exps = cell_exps[g+1];
        end
        smta_cell #(
            .IDX      (g),
            .SLOT_W   (SLOT_W),
            .CNT_W    (CNT_W),
            .EXP_BITS (EXP_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .upd_slot   (upd_slot),
            .wr_coef    (wr_coef),
            .wr_exps    (key_reg),
            .nxt_coef   (up_coef),
            .nxt_exps   (up_exps),
            .look_op    (op_t'(op)),
            .key_exps   (key_in),
            .read_index (read_index),
            .count      (count_reg),
            .coef       (cell_coef[g]),
            .exps       (cell_exps[g]),
            .sel        (cell_sel[g])
        );
    end

    // merge the single hit across the row
    always_comb
    begin
        look_hit  = 1'b0;
        look_coef = '0;
        look_exps = '0;
        look_slot = '0;
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            look_hit  = look_hit | cell_sel[i];
            look_coef = look_coef | (cell_sel[i] ? cell_coef[i] : '0);
            look_exps = look_exps | (cell_sel[i] ? cell_exps[i] : '0);
            look_slot = look_slot | (cell_sel[i] ? SLOT_W'(i) : '0);
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign sum_wide = {hcoef_reg[COEF_W-1], hcoef_reg} + {coef_reg[COEF_W-1], coef_reg};

    always_comb
    begin
        if (sum_wide[COEF_W] != sum_wide[COEF_W-1])
            sum_sat = sum_wide[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}}
                                       : {1'b0, {(COEF_W-1){1'b1}}};
        else
            sum_sat = sum_wide[COEF_W-1:0];
    end

    // update decision
    always_comb
    begin
        ctrl.shift    = 1'b0;
        ctrl.write    = 1'b0;
        upd_slot      = hslot_reg;
        wr_coef       = sum_sat;
        count_next    = count_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        coef_out_next = coef_out_reg;
        exps_out_next = exps_out_reg;
        case (op_reg)
            OP_READ:
            begin
                if (hit_reg)
                begin
                    status_next   = ST_READ_OK;
                    coef_out_next = hcoef_reg;
                    exps_out_next = hexps_reg;
                end
                else
                begin
                    status_next   = ST_READ_OOR;
                    coef_out_next = '0;
                    exps_out_next = '0;
                end
                slot_next = idx_reg;
            end
            default:
            begin
                exps_out_next = key_reg;
                if (hit_reg)
                begin
                    slot_next = 6'(hslot_reg);
                    if (sum_sat == '0)
                    begin
                        ctrl.shift    = fire;
                        count_next    = count_reg - CNT_ONE;
                        status_next   = ST_REMOVED;
                        coef_out_next = '0;
                    end
                    else
                    begin
                        ctrl.write    = fire;
                        status_next   = ST_MERGED;
                        coef_out_next = sum_sat;
                    end
                end
                else if (count_reg < CNT_MAX)
                begin
                    ctrl.write    = fire;
                    upd_slot      = SLOT_W'(count_reg);
                    wr_coef       = coef_reg;
                    count_next    = count_reg + CNT_ONE;
                    status_next   = ST_APPENDED;
                    slot_next     = 6'(count_reg);
                    coef_out_next = coef_reg;
                end
                else
                begin
                    status_next   = ST_FULL;
                    slot_next     = '0;
                    coef_out_next = coef_reg;
                end
            end
        endcase
        tc_next = 7'(count_next);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                count_reg <= count_next;
        end
    end

    // hold the item and its lookup
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(op);
            coef_reg  <= coef_in;
            key_reg   <= key_in;
            idx_reg   <= read_index;
            hit_reg   <= look_hit;
            hcoef_reg <= look_coef;
            hexps_reg <= look_exps;
            hslot_reg <= look_slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg   <= status_next;
            slot_reg     <= slot_next;
            coef_out_reg <= coef_out_next;
            exps_out_reg <= exps_out_next;
            tc_reg       <= tc_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign coef_out   = coef_out_reg;
    assign exp_x_out  = 8'(exps_out_reg[EXP_BITS-1:0]);
    assign exp_y_out  = 8'(exps_out_reg[2*EXP_BITS-1:EXP_BITS]);
    assign exp_z_out  = 8'(exps_out_reg[3*EXP_BITS-1:2*EXP_BITS]);
    assign term_count = tc_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("term count beyond table size");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> $onehot0(cell_sel))
        else $error("more than one cell hit");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CNT_ONE) ||
             (count_reg + CNT_ONE == $past(count_reg))))
        else $error("term count moved by more than one");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised outside update cycle");

endmodule

// ----- test/sparse_monomial_term_accumulator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_monomial_term_accumulator_test
// Self-checking bench for the sparse three-variable term accumulator.
// ----------------------------------------------------------------------------
// A short table of directed items hits the coefficient extremes, both
// saturation directions, zero-coefficient appends, merges to zero with the
// table shifting down, and reads in and out of range. A random part follows.
// It alternates between growing the table until it is full and draining it
// through cancelling merges. Each result is checked against a local model of
// the term table or a fixed row's given result. Idling moves between the
// sender and the receiver, and a long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------
module sparse_monomial_term_accumulator_test;
    import smta_pkg::*;

    localparam int  TERMS       = MAX_TERMS_DEF;
    localparam int  RANDOM_ITEMS = 1030;
    localparam int  CYCLE_LIMIT = 200000;
    localparam longint COEF_MAX = longint'($signed(32'h7fffffff));
    localparam longint COEF_MIN = longint'($signed(32'h80000000));

    typedef struct packed {
        status_t            status;
        logic [5:0]         slot;
        logic signed [31:0] coef;
        logic [7:0]         ex;
        logic [7:0]         ey;
        logic [7:0]         ez;
        logic [6:0]         count;
    } term_result_t;

    typedef struct {
        op_t          op;
        logic [31:0]  coef;
        logic [7:0]   x;
        logic [7:0]   y;
        logic [7:0]   z;
        logic [5:0]   idx;
        bit           typed;
        term_result_t res;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    op_t                op = OP_ADD;
    logic signed [31:0] coef_in = '0;
    logic [7:0]         exp_x_in = '0;
    logic [7:0]         exp_y_in = '0;
    logic [7:0]         exp_z_in = '0;
    logic [5:0]         read_index = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic [5:0]         slot;
    logic signed [31:0] coef_out;
    logic [7:0]         exp_x_out;
    logic [7:0]         exp_y_out;
    logic [7:0]         exp_z_out;
    logic [6:0]         term_count;

    logic signed [31:0] coef_tbl [TERMS];
    logic [23:0]        exp_tbl [TERMS];
    int                 held_count = 0;

    term_result_t       pending_terms [$];
    stim_row_t          directed_rows [$];
    bit                 typed_check = 1'b0;
    term_result_t       typed_result;
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 tx_idle_pct = 9;
    int                 rx_idle_pct = 52;
    int                 hold_left = 0;
    bit                 grow_mode = 1'b1;
    int                 full_tries = 0;

    sparse_monomial_term_accumulator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .coef_in    (coef_in),
        .exp_x_in   (exp_x_in),
        .exp_y_in   (exp_y_in),
        .exp_z_in   (exp_z_in),
        .read_index (read_index),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot       (slot),
        .coef_out   (coef_out),
        .exp_x_out  (exp_x_out),
        .exp_y_out  (exp_y_out),
        .exp_z_out  (exp_z_out),
        .term_count (term_count)
    );

    always #5 clk = ~clk;

    function automatic term_result_t predict_term(op_t o, logic [31:0] c, logic [7:0] x,
                                                  logic [7:0] y, logic [7:0] z,
                                                  logic [5:0] idx);
        term_result_t r;
        logic [23:0]  key;
        longint       sum;
        int           hit;
        key = {z, y, x};
        r = '0;
        hit = -1;
        if (o == OP_READ) begin
            r.slot = idx;
            if (int'(idx) < held_count) begin
                r.status = ST_READ_OK;
                r.coef = coef_tbl[idx];
                {r.ez, r.ey, r.ex} = exp_tbl[idx];
            end
            else begin
                r.status = ST_READ_OOR;
            end
            r.count = 7'(held_count);
            return r;
        end
        for (int i = 0; i < held_count; i++)
            if (hit < 0 && exp_tbl[i] == key)
                hit = i;
        {r.ez, r.ey, r.ex} = key;
        if (hit >= 0) begin
            sum = longint'(coef_tbl[hit]) + longint'($signed(c));
            if (sum > COEF_MAX)
                sum = COEF_MAX;
            if (sum < COEF_MIN)
                sum = COEF_MIN;
            r.slot = 6'(hit);
            if (sum == 0) begin
                for (int j = hit; j < held_count - 1; j++) begin
                    coef_tbl[j] = coef_tbl[j + 1];
                    exp_tbl[j]  = exp_tbl[j + 1];
                end
                held_count--;
                r.status = ST_REMOVED;
                r.coef = '0;
            end
            else begin
                coef_tbl[hit] = sum[31:0];
                r.status = ST_MERGED;
                r.coef = sum[31:0];
            end
        end
        else if (held_count < TERMS) begin
            coef_tbl[held_count] = c;
            exp_tbl[held_count] = key;
            r.slot = 6'(held_count);
            held_count++;
            r.status = ST_APPENDED;
            r.coef = c;
        end
        else begin
            r.status = ST_FULL;
            r.slot = '0;
            r.coef = c;
        end
        r.count = 7'(held_count);
        return r;
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'h00000001;
            4: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pool_exp();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'hff;
            default: return 8'($urandom_range(0, 7));
        endcase
    endfunction

    task automatic row_pred(op_t o, logic [31:0] c, logic [7:0] x, logic [7:0] y,
                            logic [7:0] z, logic [5:0] idx);
        stim_row_t s;
        s.op = o;
        s.coef = c;
        s.x = x;
        s.y = y;
        s.z = z;
        s.idx = idx;
        s.typed = 1'b0;
        s.res = '0;
        directed_rows.push_back(s);
    endtask

    task automatic row_fixed(op_t o, logic [31:0] c, logic [7:0] x, logic [7:0] y,
                             logic [7:0] z, logic [5:0] idx, status_t st,
                             logic [5:0] sl, logic [31:0] rc, logic [6:0] cnt);
        stim_row_t s;
        s.op = o;
        s.coef = c;
        s.x = x;
        s.y = y;
        s.z = z;
        s.idx = idx;
        s.typed = 1'b1;
        s.res = '{status: st, slot: sl, coef: rc, ex: x, ey: y, ez: z, count: cnt};
        directed_rows.push_back(s);
    endtask

    task automatic next_random(output stim_row_t s);
        int          r;
        int          pick;
        int          merge_top;
        int          cancel_top;
        s.typed = 1'b0;
        s.res = '0;
        s.op = OP_ADD;
        s.coef = rand_coef();
        {s.z, s.y, s.x} = 24'($urandom);
        s.idx = 6'($urandom);
        if (held_count == TERMS)
            full_tries++;
        if (grow_mode && held_count == TERMS && full_tries > 4) begin
            grow_mode = 1'b0;
            full_tries = 0;
        end
        else if (!grow_mode && held_count < 6) begin
            grow_mode = 1'b1;
        end
        merge_top  = grow_mode ? 25 : 70;
        cancel_top = grow_mode ? 20 : 55;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            s.op = OP_READ;
            if (held_count > 0 && r < 12)
                s.idx = 6'($urandom_range(0, held_count - 1));
        end
        else if (held_count > 0 && r < merge_top) begin
            pick = $urandom_range(0, held_count - 1);
            {s.z, s.y, s.x} = exp_tbl[pick];
            if (r < cancel_top)
                s.coef = -coef_tbl[pick];
        end
        else if (!grow_mode) begin
            s.x = pool_exp();
            s.y = pool_exp();
            s.z = pool_exp();
        end
    endtask

    task automatic offer(stim_row_t s);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        op = s.op;
        coef_in = s.coef;
        exp_x_in = s.x;
        exp_y_in = s.y;
        exp_z_in = s.z;
        read_index = s.idx;
        typed_check = s.typed;
        typed_result = s.res;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_terms.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready = 1'b0;
        end
        else begin
            out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin : monitor
        term_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_terms.size() == 0) begin
                    mismatch_count++;
                    $display("%0t mismatch: unexpected beat, actual status %0d slot %0d",
                             $time, status, slot);
                end
                else begin
                    want = pending_terms.pop_front();
                    check_field("status", want.status, status);
                    check_field("slot", want.slot, slot);
                    check_field("coef_out", want.coef, coef_out);
                    check_field("exp_x_out", want.ex, exp_x_out);
                    check_field("exp_y_out", want.ey, exp_y_out);
                    check_field("exp_z_out", want.ez, exp_z_out);
                    check_field("term_count", want.count, term_count);
                end
            end
            if (in_valid && in_ready) begin
                want = predict_term(op, coef_in, exp_x_in, exp_y_in, exp_z_in, read_index);
                if (typed_check)
                    want = typed_result;
                pending_terms.push_back(want);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[sparse_monomial_term_accumulator] ERROR");
            $finish;
        end
    end

    initial begin
        stim_row_t s;

        row_fixed(OP_READ, 32'h0, 8'h00, 8'h00, 8'h00, 6'd0, ST_READ_OOR, 6'd0, 32'h0, 7'd0);
        row_fixed(OP_READ, 32'h0, 8'h00, 8'h00, 8'h00, 6'd63, ST_READ_OOR, 6'd63, 32'h0, 7'd0);
        row_fixed(OP_ADD, 32'h7fffffff, 8'hff, 8'hff, 8'hff, 6'd0,
                  ST_APPENDED, 6'd0, 32'h7fffffff, 7'd1);
        row_fixed(OP_ADD, 32'h00000001, 8'hff, 8'hff, 8'hff, 6'd0,
                  ST_MERGED, 6'd0, 32'h7fffffff, 7'd1);
        row_fixed(OP_READ, 32'hdeadbeef, 8'hff, 8'hff, 8'hff, 6'd0,
                  ST_READ_OK, 6'd0, 32'h7fffffff, 7'd1);
        row_fixed(OP_ADD, 32'h80000000, 8'h00, 8'h00, 8'h00, 6'd63,
                  ST_APPENDED, 6'd1, 32'h80000000, 7'd2);
        row_fixed(OP_ADD, 32'hffffffff, 8'h00, 8'h00, 8'h00, 6'd0,
                  ST_MERGED, 6'd1, 32'h80000000, 7'd2);
        row_fixed(OP_ADD, 32'h0, 8'h01, 8'h02, 8'h03, 6'd0, ST_APPENDED, 6'd2, 32'h0, 7'd3);
        row_fixed(OP_ADD, 32'h0, 8'h01, 8'h02, 8'h03, 6'd0, ST_REMOVED, 6'd2, 32'h0, 7'd2);
        row_pred(OP_ADD, 32'h00000005, 8'h04, 8'h05, 8'h06, 6'd0);
        row_fixed(OP_ADD, 32'h80000001, 8'hff, 8'hff, 8'hff, 6'd0,
                  ST_REMOVED, 6'd0, 32'h0, 7'd2);
        row_pred(OP_READ, 32'h0, 8'h00, 8'h00, 8'h00, 6'd0);
        row_pred(OP_READ, 32'hffffffff, 8'hff, 8'hff, 8'hff, 6'd1);
        row_fixed(OP_READ, 32'h0, 8'h00, 8'h00, 8'h00, 6'd2, ST_READ_OOR, 6'd2, 32'h0, 7'd2);
        row_pred(OP_ADD, 32'h00010000, 8'haa, 8'h55, 8'h0f, 6'd21);
        row_pred(OP_ADD, 32'hffff0000, 8'haa, 8'h55, 8'h0f, 6'd42);
        row_pred(OP_ADD, 32'h80000000, 8'h00, 8'h00, 8'h00, 6'd0);
        row_pred(OP_ADD, 32'h7fffffff, 8'h00, 8'h00, 8'h00, 6'd0);
        row_pred(OP_ADD, 32'h00000001, 8'h00, 8'h00, 8'h00, 6'd0);
        row_pred(OP_READ, 32'h0, 8'h00, 8'h00, 8'h00, 6'd0);
        row_fixed(OP_READ, 32'h0, 8'h00, 8'h00, 8'h00, 6'd42, ST_READ_OOR, 6'd42, 32'h0, 7'd1);
        row_pred(OP_ADD, 32'h12345678, 8'h80, 8'h01, 8'hfe, 6'd0);
        row_pred(OP_ADD, 32'hfffffffb, 8'h04, 8'h05, 8'h06, 6'd0);

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            offer(directed_rows[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 330) begin
                drain_results();
                tx_idle_pct = 52;
                rx_idle_pct = 9;
            end
            if (n == 680) begin
                drain_results();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_left = 300;
            end
            next_random(s);
            offer(s);
        end
        drain_results();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("[sparse_monomial_term_accumulator] OK");
        else
            $display("[sparse_monomial_term_accumulator] ERROR");
        $finish;
    end

endmodule
